FILE: src/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define IEBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define IEBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ieba_pkg.sv
// Package for the I2C EEPROM byte access unit: item and result types, sequencer
// state, stage codes and the stage entry function. No dependencies.
`default_nettype none

package ieba_pkg;

  localparam logic [7:0] DEV_WRITE   = 8'hA0;
  localparam logic [7:0] DEV_READ    = 8'hA1;
  localparam logic [7:0] ACK_TIMEOUT = 8'd250;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_START  = 4'd1,
    ST_DEV    = 4'd2,
    ST_HIGH   = 4'd3,
    ST_LOW    = 4'd4,
    ST_WDATA  = 4'd5,
    ST_RSTART = 4'd6,
    ST_RDEV   = 4'd7,
    ST_RX     = 4'd8,
    ST_NACK   = 4'd9,
    ST_STOP   = 4'd10
  } stage_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_error;
  } result_t;

  typedef struct packed {
    stage_t      stage;
    logic [2:0]  sub;
    logic [2:0]  bit_cnt;
    logic [7:0]  shift;
    logic [7:0]  wait_cnt;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        is_read;
    logic        err;
    logic        wide;
    logic [7:0]  last_read;
  } seq_state_t;

  // Enter a stage: clear the per-stage counters and load the byte to send.
  function automatic seq_state_t enter_stage(seq_state_t s, stage_t st);
    seq_state_t r;
    r = s;
    r.stage    = st;
    r.sub      = 3'd0;
    r.bit_cnt  = 3'd0;
    r.wait_cnt = 8'd0;
    unique case (st)
      ST_DEV: begin
        if (s.wide) begin
          r.shift = DEV_WRITE;
        end else begin
          r.shift = DEV_WRITE | {4'b0000, s.addr[10:8], 1'b0};
        end
      end
      ST_HIGH:  r.shift = s.addr[15:8];
      ST_LOW:   r.shift = s.addr[7:0];
      ST_WDATA: r.shift = s.data;
      ST_RDEV:  r.shift = DEV_READ;
      default:  r.shift = 8'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/ieba_in_stage.sv
// Input register of the I2C EEPROM byte access unit: holds one accepted tick.
// Uses ieba_pkg for the item type.
`default_nettype none

module ieba_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire ieba_pkg::item_t in_item,
  input  wire logic          take,
  output logic               item_valid,
  output ieba_pkg::item_t    item
);

  logic            valid_r;
  ieba_pkg::item_t item_r;

  // Free when empty or when the held tick moves on in this cycle.
  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: src/ieba_core.sv
// Pin-step sequencer of the I2C EEPROM byte access unit: one bus step per tick.
// Uses ieba_pkg for types, stage codes and the stage entry function.
`default_nettype none

module ieba_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_en,
  input  wire logic            two_byte_address,
  input  wire ieba_pkg::item_t item,
  output ieba_pkg::result_t    result
);

  ieba_pkg::seq_state_t st_r;
  ieba_pkg::seq_state_t st_nxt;

  always_comb begin
    ieba_pkg::seq_state_t s;
    ieba_pkg::stage_t     after;
    logic scl;
    logic pull;
    logic busy;
    logic done;
    s     = st_r;
    after = ieba_pkg::ST_STOP;
    scl   = 1'b1;
    pull  = 1'b0;
    busy  = 1'b1;
    done  = 1'b0;

    // A command is only taken when idle, and its tick already runs the start.
    if (s.stage == ieba_pkg::ST_IDLE &&
        (item.cmd == ieba_pkg::CMD_READ || item.cmd == ieba_pkg::CMD_WRITE)) begin
      s.wide    = two_byte_address;
      s.addr    = two_byte_address ? item.address : {5'b00000, item.address[10:0]};
      s.data    = item.write_data;
      s.is_read = (item.cmd == ieba_pkg::CMD_READ);
      s.err     = 1'b0;
      s         = ieba_pkg::enter_stage(s, ieba_pkg::ST_START);
    end

    unique case (s.stage)
      ieba_pkg::ST_START, ieba_pkg::ST_RSTART: begin
        scl  = (s.sub == 3'd1) || (s.sub == 3'd2);
        pull = (s.sub >= 3'd2);
        if (s.sub >= 3'd3) begin
          s = ieba_pkg::enter_stage(s, (s.stage == ieba_pkg::ST_START) ?
                                       ieba_pkg::ST_DEV : ieba_pkg::ST_RDEV);
        end else begin
          s.sub = s.sub + 3'd1;
        end
      end
      ieba_pkg::ST_DEV, ieba_pkg::ST_HIGH, ieba_pkg::ST_LOW,
      ieba_pkg::ST_WDATA, ieba_pkg::ST_RDEV: begin
        priority if (s.sub <= 3'd2) begin
          scl  = (s.sub == 3'd1);
          pull = !s.shift[7];
          priority if (s.sub < 3'd2) begin
            s.sub = s.sub + 3'd1;
          end else if (s.bit_cnt == 3'd7) begin
            s.sub = 3'd3;
          end else begin
            s.bit_cnt = s.bit_cnt + 3'd1;
            s.shift   = {s.shift[6:0], 1'b0};
            s.sub     = 3'd0;
          end
        end else if (s.sub == 3'd3) begin
          scl   = 1'b0;
          s.sub = 3'd4;
        end else if (s.sub == 3'd4) begin
          // Ack slot: SDA released, SCL high, poll until the slave pulls low or the wait count reaches ACK_TIMEOUT.
          scl = 1'b1;
          priority if (!item.sda_in) begin
            s.sub = 3'd5;
          end else if (s.wait_cnt >= ieba_pkg::ACK_TIMEOUT) begin
            s.err = 1'b1;
            s     = ieba_pkg::enter_stage(s, ieba_pkg::ST_STOP);
          end else begin
            s.wait_cnt = s.wait_cnt + 8'd1;
          end
        end else begin
          scl = 1'b0;
          unique case (s.stage)
            ieba_pkg::ST_DEV:  after = s.wide ? ieba_pkg::ST_HIGH : ieba_pkg::ST_LOW;
            ieba_pkg::ST_HIGH: after = ieba_pkg::ST_LOW;
            ieba_pkg::ST_LOW:  after = s.is_read ? ieba_pkg::ST_RSTART : ieba_pkg::ST_WDATA;
            ieba_pkg::ST_RDEV: after = ieba_pkg::ST_RX;
            default:           after = ieba_pkg::ST_STOP;
          endcase
          s = ieba_pkg::enter_stage(s, after);
        end
      end
      ieba_pkg::ST_RX: begin
        if (s.sub == 3'd0) begin
          scl     = 1'b1;
          s.shift = {s.shift[6:0], item.sda_in};
          s.sub   = 3'd1;
        end else begin
          scl = 1'b0;
          if (s.bit_cnt == 3'd7) begin
            s.last_read = s.shift;
            s           = ieba_pkg::enter_stage(s, ieba_pkg::ST_NACK);
          end else begin
            s.bit_cnt = s.bit_cnt + 3'd1;
            s.sub     = 3'd0;
          end
        end
      end
      ieba_pkg::ST_NACK: begin
        scl = (s.sub == 3'd1);
        if (s.sub >= 3'd2) begin
          s = ieba_pkg::enter_stage(s, ieba_pkg::ST_STOP);
        end else begin
          s.sub = s.sub + 3'd1;
        end
      end
      ieba_pkg::ST_STOP: begin
        scl  = (s.sub >= 3'd1);
        pull = (s.sub < 3'd2);
        if (s.sub >= 3'd2) begin
          done    = 1'b1;
          s.stage = ieba_pkg::ST_IDLE;
          s.sub   = 3'd0;
        end else begin
          s.sub = s.sub + 3'd1;
        end
      end
      default: begin
        s.stage = ieba_pkg::ST_IDLE;
        s.sub   = 3'd0;
        busy    = 1'b0;
      end
    endcase

    st_nxt              = s;
    result.scl_level    = scl;
    result.sda_pull_low = pull;
    result.busy_res     = busy;
    result.done_res     = done;
    result.read_byte    = s.last_read;
    result.ack_error    = s.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/i2c_eeprom_byte_access_unit.sv
// Top level of the I2C EEPROM byte access unit: input register, sequencer and
// result register. Uses ieba_pkg, ieba_in_stage and ieba_core.
//
//  channel  | direction | carries
//  ---------+-----------+-------------------------------------------------
//  in_      | slave     | one bus tick: command, address, data, SDA sample
//  out_     | master    | pin levels and status for that tick
//  cfg_     | write     | two_byte_address mode bit
//
// A transfer lands in the input register; the sequencer does the pin step and
// the result register loads it once that register is empty or being taken, so
// each result passes through both registers on its way out, and one tick per
// cycle passes when out_tready stays high.
// Reset (rst_n low, synchronous) empties both registers, returns the sequencer
// to idle and clears the mode bit, the error flag and the last read byte.
// A stall on out_tready holds the result; the input register can still take
// one more tick, and in_tready stays low while it holds that tick.
`default_nettype none

module i2c_eeprom_byte_access_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] address, [23:16] write_data, [24] sda_in, [31:25] zero
  input  wire logic [31:0] in_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res,
  // [11:4] read_byte, [12] ack_error, [15:13] zero
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data
);

  ieba_pkg::item_t   in_item;
  ieba_pkg::item_t   item;
  ieba_pkg::result_t result;
  ieba_pkg::result_t result_r;
  logic              item_valid;
  logic              take;
  logic              out_valid_r;
  logic              two_byte_r;

  // Unpack the slave-side transfer into the item fields.
  assign in_item.cmd        = in_tuser;
  assign in_item.address    = in_tdata[15:0];
  assign in_item.write_data = in_tdata[23:16];
  assign in_item.sda_in     = in_tdata[24];

  // The held tick steps the sequencer when the result register can take it.
  assign take = item_valid && (!out_valid_r || out_tready);

  // Mode bit; the sequencer latches it only when a command starts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_byte_r <= 1'b0;
    end else if (cfg_wr_en) begin
      two_byte_r <= cfg_wr_data;
    end
  end

  ieba_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ieba_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (take),
    .two_byte_address (two_byte_r),
    .item             (item),
    .result           (result)
  );

  // Result register: loads on every step, empties when the master side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, result_r.ack_error, result_r.read_byte,
                       result_r.done_res, result_r.busy_res,
                       result_r.sda_pull_low, result_r.scl_level};

endmodule

`default_nettype wire

FILE: src/ieba_checker.sv
// Port-level checker for the I2C EEPROM byte access unit, bound to the top level.
// Uses the macros of assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ieba_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // The finishing stop tick is always a busy tick.
  `IEBA_ASSERT(a_done_busy, (out_tvalid && out_tdata[3]) |-> out_tdata[2], "done without busy")

  // An idle tick leaves the bus in its released state.
  `IEBA_ASSERT(a_idle_bus, (out_tvalid && !out_tdata[2]) |-> (out_tdata[0] && !out_tdata[1]), "idle tick drives the bus")

  // A held result stays put until taken.
  `IEBA_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled result changed")

  // No result is offered in the cycle after a reset edge.
  `IEBA_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind i2c_eeprom_byte_access_unit ieba_checker u_ieba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for i2c_eeprom_byte_access_unit: a directed table of bus ticks, then
// random read and write sequences with an acking, noisy or silent SDA responder.
// Uses ieba_pkg for the item, result and stage types; needs nothing but the RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_SPARE      = 2'd3;  // unused code, behaves as a plain tick
  localparam int         RUN            = 0;     // repeat count: tick until the bus is idle
  localparam int         TOTAL_TICKS    = 1550;
  localparam int         SETTLE_CYCLES  = 4;     // two pipeline registers plus margin
  localparam int         HOLDOFF_CYCLES = 80;
  localparam int         SHOW_LIMIT     = 10;

  typedef enum logic { ROW_TICKS, ROW_MODE } row_kind_t;
  typedef enum logic [1:0] { SDA_ACKING, SDA_NOISY, SDA_STARVE } sda_policy_t;
  typedef enum logic [1:0] { RDY_FREE, RDY_LIGHT, RDY_HEAVY, RDY_PATTERN } ready_mode_t;

  // One line of the directed table. For ROW_MODE the sda column holds the mode bit.
  typedef struct packed {
    row_kind_t           kind;
    logic [1:0]          cmd;
    logic [15:0]         addr;
    logic [7:0]          wdata;
    logic                sda;
    logic [9:0]          reps;
    logic                ack;
    logic                typed;
    ieba_pkg::result_t   want;
  } stim_row_t;

  localparam ieba_pkg::result_t BUS_IDLE   = '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam ieba_pkg::result_t FIRST_STEP = '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
  localparam ieba_pkg::result_t NO_WANT    = '0;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;
  logic [1:0]  in_tuser    = ieba_pkg::CMD_TICK;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;

  i2c_eeprom_byte_access_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bus sequencer model. State mirrors the block: stage, pin step within the
  // stage, bit counter, outgoing byte, ack poll counter and the latched command.
  // ---------------------------------------------------------------------------
  logic              wide_cfg;
  ieba_pkg::stage_t  sq_stage;
  logic [2:0]        sq_sub;
  logic [2:0]        sq_bits;
  logic [7:0]        sq_shift;
  logic [7:0]        sq_wait;
  logic [15:0]       sq_addr;
  logic [7:0]        sq_data;
  logic              sq_rd;
  logic              sq_err;
  logic              sq_wide;
  logic [7:0]        sq_last;

  int n_reads, n_writes, n_timeouts, n_mode_writes;

  function automatic void begin_phase(input ieba_pkg::stage_t st);
    sq_stage = st;
    sq_sub   = 3'd0;
    sq_bits  = 3'd0;
    sq_wait  = 8'd0;
    case (st)
      ieba_pkg::ST_DEV: begin
        // Small devices carry address bits 10..8 as page bits of the device byte.
        if (sq_wide) sq_shift = ieba_pkg::DEV_WRITE;
        else         sq_shift = ieba_pkg::DEV_WRITE | {4'b0000, sq_addr[10:8], 1'b0};
      end
      ieba_pkg::ST_HIGH:  sq_shift = sq_addr[15:8];
      ieba_pkg::ST_LOW:   sq_shift = sq_addr[7:0];
      ieba_pkg::ST_WDATA: sq_shift = sq_data;
      ieba_pkg::ST_RDEV:  sq_shift = ieba_pkg::DEV_READ;
      default:            sq_shift = 8'h00;
    endcase
  endfunction

  // Pin levels and status for one bus tick; advances the model by that tick.
  function automatic ieba_pkg::result_t eeprom_tick(input ieba_pkg::item_t it);
    ieba_pkg::result_t r;
    r.scl_level    = 1'b1;
    r.sda_pull_low = 1'b0;
    r.busy_res     = 1'b1;
    r.done_res     = 1'b0;
    if (sq_stage == ieba_pkg::ST_IDLE &&
        (it.cmd == ieba_pkg::CMD_READ || it.cmd == ieba_pkg::CMD_WRITE)) begin
      sq_wide = wide_cfg;
      sq_addr = wide_cfg ? it.address : {5'd0, it.address[10:0]};
      sq_data = it.write_data;
      sq_rd   = (it.cmd == ieba_pkg::CMD_READ);
      sq_err  = 1'b0;
      if (sq_rd) n_reads++;
      else       n_writes++;
      begin_phase(ieba_pkg::ST_START);
    end
    case (sq_stage)
      ieba_pkg::ST_START, ieba_pkg::ST_RSTART: begin
        r.scl_level    = (sq_sub == 3'd1 || sq_sub == 3'd2);
        r.sda_pull_low = (sq_sub >= 3'd2);
        if (sq_sub >= 3'd3) begin
          if (sq_stage == ieba_pkg::ST_START) begin_phase(ieba_pkg::ST_DEV);
          else                                begin_phase(ieba_pkg::ST_RDEV);
        end else begin
          sq_sub++;
        end
      end
      ieba_pkg::ST_DEV, ieba_pkg::ST_HIGH, ieba_pkg::ST_LOW,
      ieba_pkg::ST_WDATA, ieba_pkg::ST_RDEV: begin
        if (sq_sub <= 3'd2) begin
          r.scl_level    = (sq_sub == 3'd1);
          r.sda_pull_low = ~sq_shift[7];
          if (sq_sub < 3'd2) begin
            sq_sub++;
          end else if (sq_bits == 3'd7) begin
            sq_sub = 3'd3;
          end else begin
            sq_bits++;
            sq_shift = sq_shift << 1;
            sq_sub   = 3'd0;
          end
        end else if (sq_sub == 3'd3) begin
          r.scl_level = 1'b0;
          sq_sub      = 3'd4;
        end else if (sq_sub == 3'd4) begin
          // Ack slot: SDA released, SCL high, poll until low or timeout.
          r.scl_level = 1'b1;
          if (!it.sda_in) begin
            sq_sub = 3'd5;
          end else if (sq_wait >= ieba_pkg::ACK_TIMEOUT) begin
            sq_err = 1'b1;
            begin_phase(ieba_pkg::ST_STOP);
          end else begin
            sq_wait++;
          end
        end else begin
          r.scl_level = 1'b0;
          case (sq_stage)
            ieba_pkg::ST_DEV: begin
              if (sq_wide) begin_phase(ieba_pkg::ST_HIGH);
              else         begin_phase(ieba_pkg::ST_LOW);
            end
            ieba_pkg::ST_HIGH: begin_phase(ieba_pkg::ST_LOW);
            ieba_pkg::ST_LOW: begin
              if (sq_rd) begin_phase(ieba_pkg::ST_RSTART);
              else       begin_phase(ieba_pkg::ST_WDATA);
            end
            ieba_pkg::ST_RDEV: begin_phase(ieba_pkg::ST_RX);
            default:           begin_phase(ieba_pkg::ST_STOP);
          endcase
        end
      end
      ieba_pkg::ST_RX: begin
        if (sq_sub == 3'd0) begin
          r.scl_level = 1'b1;
          sq_shift    = {sq_shift[6:0], it.sda_in};
          sq_sub      = 3'd1;
        end else begin
          r.scl_level = 1'b0;
          if (sq_bits == 3'd7) begin
            sq_last = sq_shift;
            begin_phase(ieba_pkg::ST_NACK);
          end else begin
            sq_bits++;
            sq_sub = 3'd0;
          end
        end
      end
      ieba_pkg::ST_NACK: begin
        r.scl_level = (sq_sub == 3'd1);
        if (sq_sub >= 3'd2) begin_phase(ieba_pkg::ST_STOP);
        else                sq_sub++;
      end
      ieba_pkg::ST_STOP: begin
        r.scl_level    = (sq_sub >= 3'd1);
        r.sda_pull_low = (sq_sub < 3'd2);
        if (sq_sub >= 3'd2) begin
          r.done_res = 1'b1;
          if (sq_err) n_timeouts++;
          sq_stage = ieba_pkg::ST_IDLE;
          sq_sub   = 3'd0;
        end else begin
          sq_sub++;
        end
      end
      default: begin
        sq_stage   = ieba_pkg::ST_IDLE;
        sq_sub     = 3'd0;
        r.busy_res = 1'b0;
      end
    endcase
    r.read_byte = sq_last;
    r.ack_error = sq_err;
    return r;
  endfunction

  // SDA level the responder offers on the next tick, given the model state.
  function automatic logic pick_sda(input sda_policy_t pol,
                                    input ieba_pkg::stage_t starve_at);
    logic at_poll;
    logic v;
    at_poll = (sq_sub == 3'd4);  // pin step four exists only in the ack slot
    v = 1'($urandom_range(0, 1));
    case (pol)
      SDA_NOISY:  v = 1'($urandom_range(0, 1));
      SDA_STARVE: begin
        if (at_poll && sq_stage == starve_at) v = 1'b1;
        else if (at_poll)                     v = ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (at_poll) v = ($urandom_range(0, 3) == 0);
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps. Each tick is predicted
  // when it is offered and its pin levels are queued once the transfer happens.
  // ---------------------------------------------------------------------------
  ieba_pkg::result_t pending_pins[$];
  int                sent_count;
  int                burst_left;
  bit                holdoff_arm;

  task automatic send_tick(input ieba_pkg::item_t it, input logic typed,
                           input ieba_pkg::result_t want);
    ieba_pkg::result_t pins;
    int                gap;
    pins = eeprom_tick(it);
    if (typed) pins = want;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(100, 300);  // long stretch with no idling
      end else begin
        gap        = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 16);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, it.sda_in, it.write_data, it.address};
    in_tuser  <= it.cmd;
    do @(posedge clk); while (!in_tready);
    pending_pins.push_back(pins);
    sent_count++;
  endtask

  // Stop offering and let every queued result come back.
  task automatic settle_bus();
    in_tvalid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    settle_bus();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wide_cfg = v;
    n_mode_writes++;
  endtask

  // One command with random content, then ticks until the stop has gone out.
  task automatic random_transaction();
    ieba_pkg::item_t  it;
    sda_policy_t      pol;
    ieba_pkg::stage_t starve_at;
    int               pick;
    pick = $urandom_range(0, 19);
    if (pick < 2)      pol = SDA_STARVE;
    else if (pick < 4) pol = SDA_NOISY;
    else               pol = SDA_ACKING;
    case ($urandom_range(0, 4))
      0:       starve_at = ieba_pkg::ST_DEV;
      1:       starve_at = ieba_pkg::ST_HIGH;
      2:       starve_at = ieba_pkg::ST_LOW;
      3:       starve_at = ieba_pkg::ST_WDATA;
      default: starve_at = ieba_pkg::ST_RDEV;
    endcase
    // A few idle ticks first, some of them with the spare code.
    repeat ($urandom_range(0, 4)) begin
      it.cmd        = ($urandom_range(0, 3) == 0) ? CMD_SPARE : ieba_pkg::CMD_TICK;
      it.address    = 16'($urandom_range(0, 16'hFFFF));
      it.write_data = 8'($urandom_range(0, 8'hFF));
      it.sda_in     = 1'($urandom_range(0, 1));
      send_tick(it, 1'b0, NO_WANT);
    end
    it.cmd = $urandom_range(0, 1) ? ieba_pkg::CMD_READ : ieba_pkg::CMD_WRITE;
    case ($urandom_range(0, 7))
      0:       it.address = 16'h0000;
      1:       it.address = 16'hFFFF;
      2:       it.address = 16'h07FF;
      3:       it.address = 16'h0800;
      default: it.address = 16'($urandom_range(0, 16'hFFFF));
    endcase
    it.write_data = 8'($urandom_range(0, 8'hFF));
    it.sda_in     = pick_sda(pol, starve_at);
    send_tick(it, 1'b0, NO_WANT);
    // Commands that arrive while the bus is busy must be ignored.
    while (sq_stage != ieba_pkg::ST_IDLE) begin
      it.cmd        = 2'($urandom_range(0, 3));
      it.address    = 16'($urandom_range(0, 16'hFFFF));
      it.write_data = 8'($urandom_range(0, 8'hFF));
      it.sda_in     = pick_sda(pol, starve_at);
      send_tick(it, 1'b0, NO_WANT);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: changes its stall habit after each run of random length, and once holds
  // out_tready low for a long stretch so that the block backs up its input.
  // ---------------------------------------------------------------------------
  ready_mode_t rdy_mode     = RDY_FREE;
  int          rdy_run      = 0;
  int          holdoff_left = 0;
  logic [7:0]  rdy_pattern  = 8'hFF;

  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_tready <= 1'b0;
    end else if (holdoff_arm) begin
      holdoff_arm  = 1'b0;
      holdoff_left = HOLDOFF_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      if (rdy_run == 0) begin
        rdy_mode    = ready_mode_t'($urandom_range(0, 3));
        rdy_run     = $urandom_range(20, 200);
        rdy_pattern = 8'($urandom_range(0, 8'hFF)) | 8'h01;
      end
      rdy_run--;
      case (rdy_mode)
        RDY_LIGHT:   out_tready <= ($urandom_range(0, 3) != 0);
        RDY_HEAVY:   out_tready <= ($urandom_range(0, 3) == 0);
        RDY_PATTERN: begin
          out_tready <= rdy_pattern[0];
          rdy_pattern = {rdy_pattern[0], rdy_pattern[7:1]};
        end
        default:     out_tready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every result transfer is compared with the oldest queued tick.
  // ---------------------------------------------------------------------------
  int bad_pins;
  int checked;

  always @(posedge clk) begin : check_out
    ieba_pkg::result_t got;
    ieba_pkg::result_t want;
    string             diff;
    if (rst_n && out_tvalid && out_tready) begin
      got.scl_level    = out_tdata[0];
      got.sda_pull_low = out_tdata[1];
      got.busy_res     = out_tdata[2];
      got.done_res     = out_tdata[3];
      got.read_byte    = out_tdata[11:4];
      got.ack_error    = out_tdata[12];
      if (pending_pins.size() == 0) begin
        bad_pins++;
        if (bad_pins <= SHOW_LIMIT)
          $display("[%0t] result transfer with no tick outstanding: %h", $realtime, out_tdata);
      end else begin
        want = pending_pins.pop_front();
        checked++;
        diff = "";
        if (got.scl_level    !== want.scl_level)    diff = {diff, " scl_level"};
        if (got.sda_pull_low !== want.sda_pull_low) diff = {diff, " sda_pull_low"};
        if (got.busy_res     !== want.busy_res)     diff = {diff, " busy_res"};
        if (got.done_res     !== want.done_res)     diff = {diff, " done_res"};
        if (got.read_byte    !== want.read_byte)    diff = {diff, " read_byte"};
        if (got.ack_error    !== want.ack_error)    diff = {diff, " ack_error"};
        if (diff != "") begin
          bad_pins++;
          if (bad_pins <= SHOW_LIMIT) begin
            $display("[%0t] result %0d differs in%s", $realtime, checked, diff);
            $display("  want scl=%b low=%b busy=%b done=%b rd=%h err=%b",
                     want.scl_level, want.sda_pull_low, want.busy_res, want.done_res,
                     want.read_byte, want.ack_error);
            $display("  got  scl=%b low=%b busy=%b done=%b rd=%h err=%b",
                     got.scl_level, got.sda_pull_low, got.busy_res, got.done_res,
                     got.read_byte, got.ack_error);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table.
  // ---------------------------------------------------------------------------
  stim_row_t plan[$];

  function automatic void put_row(input row_kind_t kind, input logic [1:0] cmd,
                                  input logic [15:0] addr, input logic [7:0] wdata,
                                  input logic sda, input int reps, input logic ack,
                                  input logic typed, input ieba_pkg::result_t want);
    stim_row_t r;
    r.kind  = kind;
    r.cmd   = cmd;
    r.addr  = addr;
    r.wdata = wdata;
    r.sda   = sda;
    r.reps  = 10'(reps);
    r.ack   = ack;
    r.typed = typed;
    r.want  = want;
    plan.push_back(r);
  endfunction

  initial begin : run
    stim_row_t       row;
    ieba_pkg::item_t it;
    int              n;
    int              dir_sent;

    wide_cfg      = 1'b0;
    sq_stage      = ieba_pkg::ST_IDLE;
    sq_sub        = '0;
    sq_bits       = '0;
    sq_shift      = '0;
    sq_wait       = '0;
    sq_addr       = '0;
    sq_data       = '0;
    sq_rd         = 1'b0;
    sq_err        = 1'b0;
    sq_wide       = 1'b0;
    sq_last       = '0;
    n_reads       = 0;
    n_writes      = 0;
    n_timeouts    = 0;
    n_mode_writes = 0;
    sent_count    = 0;
    burst_left    = 0;
    bad_pins      = 0;
    checked       = 0;
    holdoff_arm   = 1'b0;

    //      kind       cmd                  addr      wdata  sda   reps ack  typed want
    // Quiet bus after reset, and the spare command code on an idle bus.
    put_row(ROW_TICKS, ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b1, 3,   1'b0, 1'b1, BUS_IDLE);
    put_row(ROW_TICKS, CMD_SPARE,           16'hFFFF, 8'hFF, 1'b0, 2,   1'b0, 1'b1, BUS_IDLE);
    // Small mode: top address (masked to 11 bits), all-ones and all-zeros data.
    put_row(ROW_TICKS, ieba_pkg::CMD_WRITE, 16'hFFFF, 8'hFF, 1'b1, 1,   1'b0, 1'b1, FIRST_STEP);
    put_row(ROW_TICKS, ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b1, RUN, 1'b1, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_WRITE, 16'h0000, 8'h00, 1'b0, RUN, 1'b1, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_READ,  16'h07FF, 8'h00, 1'b1, RUN, 1'b1, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_READ,  16'h0123, 8'hFF, 1'b0, RUN, 1'b1, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b1, 1,   1'b0, 1'b1, BUS_IDLE);
    // Wide mode: separate high address byte.
    put_row(ROW_MODE,  ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b1, 1,   1'b0, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_WRITE, 16'hFFFF, 8'hA5, 1'b0, RUN, 1'b1, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_READ,  16'h8000, 8'h00, 1'b1, RUN, 1'b1, 1'b0, NO_WANT);
    // A read command that arrives in the middle of a write is dropped.
    put_row(ROW_TICKS, ieba_pkg::CMD_WRITE, 16'h1234, 8'h5A, 1'b0, 12,  1'b1, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_READ,  16'hFFFF, 8'h00, 1'b1, 6,   1'b1, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b0, RUN, 1'b1, 1'b0, NO_WANT);
    // Mode bit cleared halfway through a wide read: that read stays wide.
    put_row(ROW_TICKS, ieba_pkg::CMD_READ,  16'hABCD, 8'h00, 1'b0, 40,  1'b1, 1'b0, NO_WANT);
    put_row(ROW_MODE,  ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b0, 1,   1'b0, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b1, RUN, 1'b1, 1'b0, NO_WANT);
    // Ack that comes on the last poll before the timeout.
    put_row(ROW_TICKS, ieba_pkg::CMD_WRITE, 16'h0F0F, 8'h3C, 1'b0, 1,   1'b0, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b0, 28,  1'b0, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b1, 250, 1'b0, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b1, RUN, 1'b1, 1'b0, NO_WANT);
    // No ack at all on a read: stop, error flag, last read byte kept.
    put_row(ROW_TICKS, ieba_pkg::CMD_READ,  16'h0600, 8'h00, 1'b0, 1,   1'b0, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b0, 28,  1'b0, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b1, 251, 1'b0, 1'b0, NO_WANT);
    put_row(ROW_TICKS, ieba_pkg::CMD_TICK,  16'h0000, 8'h00, 1'b1, RUN, 1'b1, 1'b0, NO_WANT);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_MODE) begin
        write_mode(row.sda);
      end else begin
        n = 0;
        do begin
          it.cmd        = row.cmd;
          it.address    = row.addr;
          it.write_data = row.wdata;
          it.sda_in     = (row.ack && sq_sub == 3'd4) ? 1'b0 : row.sda;
          send_tick(it, row.typed, row.want);
          n++;
        end while ((row.reps == RUN) ? (sq_stage != ieba_pkg::ST_IDLE) : (n < row.reps));
      end
    end
    dir_sent = sent_count;

    // Random sequences up to the tick budget. The receiver hold-off starts with
    // the first of them, and mode writes wait until it is well over so that the
    // block really backs up.
    holdoff_arm = 1'b1;
    do begin
      if (sent_count - dir_sent > 2 * HOLDOFF_CYCLES && $urandom_range(0, 3) == 0)
        write_mode(1'($urandom_range(0, 1)));
      random_transaction();
    end while (sent_count < TOTAL_TICKS);

    settle_bus();
    if (pending_pins.size() != 0) bad_pins++;
    $display("Ran %0d bus ticks (%0d directed): %0d reads, %0d writes, %0d ack timeouts,",
             sent_count, dir_sent, n_reads, n_writes, n_timeouts);
    $display("%0d mode writes; compared %0d results, %0d failures.",
             n_mode_writes, checked, bad_pins);
    if (bad_pins == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
